>>> rtl/rps_pkg.sv
// Shared types and constants for the rain particle step block.
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;

    localparam int CFG_HALF_LENGTH   = 0;
    localparam int CFG_SPHERE_RADIUS = 1;
    localparam int CFG_RAIN_STEP_X   = 2;
    localparam int CFG_RAIN_STEP_Y   = 3;
    localparam int CFG_RAIN_STEP_Z   = 4;
    localparam int CFG_SPHERE_STEP_X = 5;
    localparam int CFG_SPHERE_STEP_Y = 6;
    localparam int CFG_SPHERE_STEP_Z = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLOOR,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_HIT,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic floor_fix;
        logic sq_x;
        logic sq_y;
        logic sq_z;
        logic hit_fix;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic floor_hit;
        logic in_box;
        logic in_sphere;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/rps_datapath.sv
// Datapath: step, wrap, relocation, distance test, centre and counters.
`timescale 1ns / 1ps
`default_nettype none
module rps_datapath #(
    parameter int RAND_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rps_pkg::cmd_t        cmd,
    output rps_pkg::stat_t            stat,
    input  wire logic [29:0]          half_length,
    input  wire logic [29:0]          sphere_radius,
    input  wire logic signed [25:0]   rain_step_x,
    input  wire logic signed [25:0]   rain_step_y,
    input  wire logic signed [25:0]   rain_step_z,
    input  wire logic signed [25:0]   sphere_step_x,
    input  wire logic signed [25:0]   sphere_step_y,
    input  wire logic signed [25:0]   sphere_step_z,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic [RAND_BITS-1:0] floor_rand_x,
    input  wire logic [RAND_BITS-1:0] floor_rand_z,
    input  wire logic [RAND_BITS-1:0] hit_rand_x,
    input  wire logic [RAND_BITS-1:0] hit_rand_z,
    input  wire logic                 last_in_frame,
    input  wire logic                 restart,
    output logic signed [31:0]        new_x,
    output logic signed [31:0]        new_y,
    output logic signed [31:0]        new_z,
    output logic                      hit_floor,
    output logic                      hit_sphere,
    output logic [31:0]               floor_total,
    output logic [31:0]               sphere_total,
    output logic                      finished
);

    localparam int PW = 31 + RAND_BITS;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [RAND_BITS-1:0] rx_reg, rz_reg, hx_reg, hz_reg;
    logic last_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic signed [32:0] cx_next, cy_next, cz_next;
    logic [31:0] fcnt_reg, scnt_reg, fcnt_next, scnt_next;
    logic done_reg, done_next;
    logic hf_reg, hs_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;

    logic signed [33:0] len, lim, sx, sy, sz, wx, wy, wz;
    logic [30:0] two_len;
    logic [PW-1:0] prod_x, prod_z;
    logic signed [33:0] relx, relz, dx, dy, dz;
    logic [31:0] mul_a;
    logic [63:0] sq;
    logic signed [33:0] nx, ny, nz;

    function automatic logic signed [33:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 34'sd2147483647;
        else if (v < -34'sd2147483648)
            sat32 = -34'sd2147483648;
        else
            sat32 = v;
    endfunction

    function automatic logic [31:0] absd(input logic signed [33:0] d);
        absd = d[33] ? 32'(-d) : d[31:0];
    endfunction

    assign len     = 34'(half_length);
    assign lim     = len + 34'(sphere_radius);
    assign two_len = {half_length, 1'b0};

    // relocation: one RAND_BITS-by-31 product for each of x and z
    assign prod_x = PW'(two_len) * PW'(cmd.floor_fix ? rx_reg : hx_reg);
    assign prod_z = PW'(two_len) * PW'(cmd.floor_fix ? rz_reg : hz_reg);
    assign relx   = 34'(prod_x >> RAND_BITS) - len;
    assign relz   = 34'(prod_z >> RAND_BITS) - len;

    assign sx = 34'(pos_x) + 34'(rain_step_x);
    assign sy = 34'(pos_y) + 34'(rain_step_y);
    assign sz = 34'(pos_z) + 34'(rain_step_z);

    always_comb
    begin
        wx = sx;
        if (wx > len)  wx = wx - 34'(two_len);
        if (wx < -len) wx = wx + 34'(two_len);
        wy = sy;
        if (wy > len)  wy = wy - 34'(two_len);
        wz = sz;
        if (wz > len)  wz = wz - 34'(two_len);
        if (wz < -len) wz = wz + 34'(two_len);
    end

    assign dx = x_reg - 34'(cx_reg);
    assign dy = y_reg - 34'(cy_reg);
    assign dz = z_reg - 34'(cz_reg);

    // one shared squarer; operands below the radius fit 30 bits
    always_comb
    begin
        mul_a = absd(dx);
        if (cmd.sq_y) mul_a = absd(dy);
        if (cmd.sq_z) mul_a = absd(dz);
    end
    assign sq = {32'd0, mul_a} * {32'd0, mul_a};

    assign stat.floor_hit = y_reg < -len;
    assign stat.in_box    = absd(dx) < 32'(sphere_radius) && absd(dy) < 32'(sphere_radius)
                            && absd(dz) < 32'(sphere_radius);
    assign stat.in_sphere = acc_reg < 64'(sphere_radius) * 64'(sphere_radius);

    assign nx = sat32(34'(cx_reg) + 34'(sphere_step_x));
    assign ny = sat32(34'(cy_reg) + 34'(sphere_step_y));
    assign nz = sat32(34'(cz_reg) + 34'(sphere_step_z));

    always_comb
    begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        fcnt_next = fcnt_reg; scnt_next = scnt_reg; done_next = done_reg;
        acc_next = acc_reg;
        if (cmd.load)
        begin
            if (restart)
            begin
                cx_next = 33'(-lim); cy_next = '0; cz_next = '0;
                fcnt_next = '0; scnt_next = '0; done_next = 1'b0;
            end
            // saturating here leaves the floor test unchanged
            x_next = sat32(wx); y_next = sat32(wy); z_next = sat32(wz);
        end
        if (cmd.floor_fix)
        begin
            x_next = sat32(relx);
            y_next = len;
            z_next = sat32(relz);
            if (fcnt_reg != '1) fcnt_next = fcnt_reg + 32'd1;
        end
        else if (!cmd.load && !cmd.hit_fix && !cmd.sq_x && !cmd.sq_y && !cmd.sq_z
                 && !cmd.finish)
        begin
            x_next = x_reg;
        end
        if (cmd.sq_x) acc_next = sq;
        if (cmd.sq_y || cmd.sq_z) acc_next = acc_reg + sq;
        if (cmd.hit_fix)
        begin
            x_next = relx; y_next = len; z_next = relz;
            if (scnt_reg != '1) scnt_next = scnt_reg + 32'd1;
        end
        if (cmd.finish && last_reg)
        begin
            cx_next = 33'(nx); cy_next = 33'(ny); cz_next = 33'(nz);
            if (nx > lim || ny > lim || nz > lim) done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            fcnt_reg <= '0; scnt_reg <= '0; done_reg <= 1'b0;
            hf_reg <= 1'b0; hs_reg <= 1'b0;
        end
        else
        begin
            cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
            fcnt_reg <= fcnt_next; scnt_reg <= scnt_next; done_reg <= done_next;
            if (cmd.load) begin hf_reg <= 1'b0; hs_reg <= 1'b0; end
            if (cmd.floor_fix) hf_reg <= 1'b1;
            if (cmd.hit_fix) hs_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            rx_reg <= floor_rand_x; rz_reg <= floor_rand_z;
            hx_reg <= hit_rand_x; hz_reg <= hit_rand_z;
            last_reg <= last_in_frame;
        end
    end

    // result register, loaded on finish
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            new_x <= x_reg[31:0]; new_y <= y_reg[31:0]; new_z <= z_reg[31:0];
            hit_floor <= hf_reg; hit_sphere <= hs_reg;
            floor_total <= fcnt_reg; sphere_total <= scnt_reg;
            finished <= done_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rps_ctrl.sv
// Controller: sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module rps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire rps_pkg::stat_t stat,
    output rps_pkg::cmd_t       cmd
);

    rps_pkg::state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rps_pkg::ST_IDLE:  if (in_valid) state_next = rps_pkg::ST_FLOOR;
            rps_pkg::ST_FLOOR: state_next = rps_pkg::ST_SQX;
            rps_pkg::ST_SQX:   state_next = rps_pkg::ST_SQY;
            rps_pkg::ST_SQY:   state_next = stat.in_box ? rps_pkg::ST_SQZ : rps_pkg::ST_OUT;
            rps_pkg::ST_SQZ:   state_next = rps_pkg::ST_HIT;
            rps_pkg::ST_HIT:   state_next = rps_pkg::ST_OUT;
            rps_pkg::ST_OUT:   if (!ov_reg || out_ready) state_next = rps_pkg::ST_IDLE;
            default:           state_next = rps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            rps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rps_pkg::ST_FLOOR: cmd.floor_fix = stat.floor_hit;
            rps_pkg::ST_SQX:   cmd.sq_x = 1'b1;
            rps_pkg::ST_SQY:   cmd.sq_y = 1'b1;
            rps_pkg::ST_SQZ:   cmd.sq_z = 1'b1;
            rps_pkg::ST_HIT:   cmd.hit_fix = stat.in_sphere;
            rps_pkg::ST_OUT:   cmd.finish = !ov_reg || out_ready;
            default:           cmd = '0;
        endcase
    end

    assign ov_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rps_pkg::ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.floor_fix, cmd.sq_x, cmd.sq_y, cmd.sq_z, cmd.hit_fix,
                  cmd.finish})) else $error("several commands at once");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid) else $error("result lost");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == rps_pkg::ST_FLOOR) else $error("load without start");

endmodule
`default_nettype wire

>>> rtl/rain_particle_step_core.sv
// Top level: configuration registers, controller and datapath.
// channel | handshake              | payload
// in      | in_valid / in_ready    | pos_*, *_rand_*, last_in_frame, restart
// out     | out_valid / out_ready  | new_*, hit_*, *_total, finished
// cfg     | APB psel/penable/pwrite| paddr, pwdata, prdata
// An item goes through load, floor fix, two passes through the shared
// squarer, and when the box test passes a third pass and the hit fix, then
// the result load.
// The result sits in an output register; the next item is taken while it waits.
// Reset clears centre, counters, finished flag and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module rain_particle_step_core #(
    parameter int RAND_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic [RAND_BITS-1:0] floor_rand_x,
    input  wire logic [RAND_BITS-1:0] floor_rand_z,
    input  wire logic [RAND_BITS-1:0] hit_rand_x,
    input  wire logic [RAND_BITS-1:0] hit_rand_z,
    input  wire logic                 last_in_frame,
    input  wire logic                 restart,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        new_x,
    output logic signed [31:0]        new_y,
    output logic signed [31:0]        new_z,
    output logic                      hit_floor,
    output logic                      hit_sphere,
    output logic [31:0]               floor_total,
    output logic [31:0]               sphere_total,
    output logic                      finished
);

    logic [29:0] hl_reg, rad_reg;
    logic signed [25:0] rsx_reg, rsy_reg, rsz_reg, ssx_reg, ssy_reg, ssz_reg;
    logic wr;
    rps_pkg::cmd_t cmd;
    rps_pkg::stat_t stat;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_reg <= 30'd655360; rad_reg <= 30'd32768;
            rsx_reg <= '0; rsy_reg <= -26'sd1638; rsz_reg <= '0;
            ssx_reg <= 26'sd328; ssy_reg <= '0; ssz_reg <= '0;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                3'(rps_pkg::CFG_HALF_LENGTH):   hl_reg  <= pwdata[29:0];
                3'(rps_pkg::CFG_SPHERE_RADIUS): rad_reg <= pwdata[29:0];
                3'(rps_pkg::CFG_RAIN_STEP_X):   rsx_reg <= pwdata[25:0];
                3'(rps_pkg::CFG_RAIN_STEP_Y):   rsy_reg <= pwdata[25:0];
                3'(rps_pkg::CFG_RAIN_STEP_Z):   rsz_reg <= pwdata[25:0];
                3'(rps_pkg::CFG_SPHERE_STEP_X): ssx_reg <= pwdata[25:0];
                3'(rps_pkg::CFG_SPHERE_STEP_Y): ssy_reg <= pwdata[25:0];
                3'(rps_pkg::CFG_SPHERE_STEP_Z): ssz_reg <= pwdata[25:0];
                default: hl_reg <= hl_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            3'(rps_pkg::CFG_HALF_LENGTH):   prdata = 32'(hl_reg);
            3'(rps_pkg::CFG_SPHERE_RADIUS): prdata = 32'(rad_reg);
            3'(rps_pkg::CFG_RAIN_STEP_X):   prdata = 32'(rsx_reg);
            3'(rps_pkg::CFG_RAIN_STEP_Y):   prdata = 32'(rsy_reg);
            3'(rps_pkg::CFG_RAIN_STEP_Z):   prdata = 32'(rsz_reg);
            3'(rps_pkg::CFG_SPHERE_STEP_X): prdata = 32'(ssx_reg);
            3'(rps_pkg::CFG_SPHERE_STEP_Y): prdata = 32'(ssy_reg);
            3'(rps_pkg::CFG_SPHERE_STEP_Z): prdata = 32'(ssz_reg);
            default:                        prdata = '0;
        endcase
    end

    rps_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    rps_datapath #(.RAND_BITS(RAND_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .half_length(hl_reg), .sphere_radius(rad_reg),
        .rain_step_x(rsx_reg), .rain_step_y(rsy_reg), .rain_step_z(rsz_reg),
        .sphere_step_x(ssx_reg), .sphere_step_y(ssy_reg), .sphere_step_z(ssz_reg),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .floor_rand_x(floor_rand_x), .floor_rand_z(floor_rand_z),
        .hit_rand_x(hit_rand_x), .hit_rand_z(hit_rand_z),
        .last_in_frame(last_in_frame), .restart(restart),
        .new_x(new_x), .new_y(new_y), .new_z(new_z),
        .hit_floor(hit_floor), .hit_sphere(hit_sphere),
        .floor_total(floor_total), .sphere_total(sphere_total), .finished(finished)
    );

endmodule
`default_nettype wire
